[sv/sobel3_pkg.sv]
// Shared types and constants for the 3x3 Sobel gradient stream core.
// Used by the configuration block, the window front end, the result issue stage and the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sobel3_pkg;

    localparam int PIX_W          = 8;
    localparam int GRAD_W         = 11;
    localparam int FRAME_WIDTH_W  = 13;
    localparam int FRAME_HEIGHT_W = 16;
    localparam int CFG_DATA_W     = 16;
    localparam int CFG_INDEX_W    = 1;
    localparam int M_TDATA_W      = 24;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    // Bit positions in the per-pixel result mask, in raster order of release.
    localparam int RES_N         = 4;
    localparam int RES_INNER     = 0;  // result one column to the left, row above
    localparam int RES_ROW_EDGE  = 1;  // right border result, row above
    localparam int RES_LAST_ROW  = 2;  // result one column to the left, last row
    localparam int RES_LAST_EDGE = 3;  // right border result, last row

    typedef logic [PIX_W-1:0]              pix_t;
    typedef logic signed [GRAD_W-1:0]      grad_t;
    typedef logic [2:0][2:0][PIX_W-1:0]    win_t;   // [row][column], row 0 on top
    typedef logic [RES_N-1:0]              res_mask_t;

    typedef struct packed {
        win_t      win;
        res_mask_t mask;
        logic      first_row;
    } job_t;

endpackage

`default_nettype wire

[sv/sobel3_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sobel3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[sv/sobel3_window.sv]
// Front end: column and row counters, the two line stores and the 3x3 window.
// Builds, for each accepted pixel, the window and the mask of results it releases.
// Depends on sobel3_pkg and sobel3_ram.
`timescale 1ns / 1ps
`default_nettype none

module sobel3_window
    import sobel3_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      accept,
    input  wire pix_t                      pixel,
    input  wire logic [FRAME_WIDTH_W-1:0]  frame_width,
    input  wire logic [FRAME_HEIGHT_W-1:0] frame_height,
    output job_t                           job
);

    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int EXT_W     = (COL_W + 1 > FRAME_WIDTH_W) ? COL_W + 1 : FRAME_WIDTH_W;
    localparam int ROW_EXT_W = FRAME_HEIGHT_W + 1;
    localparam logic [COL_W-1:0] COL_MAX = COL_W'(MAX_WIDTH - 1);

    logic [COL_W-1:0]          col_reg, col_next;
    logic [FRAME_HEIGHT_W-1:0] row_reg, row_next;
    win_t                      win_reg, win_next, win_shift;
    logic                      byp_valid_reg, byp_valid_next;
    logic [2*PIX_W-1:0]        byp_data_reg, byp_data_next;
    logic [2*PIX_W-1:0]        ram_q, line_q;
    pix_t                      older, newer;
    pix_t                      nv [3];
    logic                      last_col, last_row;

    // Both line stores share one RAM word: {older, newer}.
    sobel3_ram #(
        .WIDTH(2 * PIX_W),
        .DEPTH(MAX_WIDTH)
    ) u_line_ram (
        .aclk (aclk),
        .we   (accept),
        .waddr(col_reg),
        .wdata({newer, pixel}),
        .raddr(col_next),
        .rdata(ram_q)
    );

    // A write and a read of the same entry in one cycle is forwarded.
    assign line_q = byp_valid_reg ? byp_data_reg : ram_q;
    assign older  = line_q[2*PIX_W-1:PIX_W];
    assign newer  = line_q[PIX_W-1:0];

    // A width of zero acts as one, and a width above the line store acts as its depth.
    assign last_col = (EXT_W'(frame_width) <= EXT_W'(col_reg) + EXT_W'(1))
                   || (col_reg == COL_MAX);
    assign last_row = (ROW_EXT_W'(frame_height) <= ROW_EXT_W'(row_reg) + ROW_EXT_W'(1));

    assign nv[0] = (row_reg <= FRAME_HEIGHT_W'(1)) ? newer : older;
    assign nv[1] = newer;
    assign nv[2] = pixel;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (col_reg == '0) begin
                win_shift[i][0] = nv[i];
                win_shift[i][1] = nv[i];
                win_shift[i][2] = nv[i];
            end else begin
                win_shift[i][0] = win_reg[i][1];
                win_shift[i][1] = win_reg[i][2];
                win_shift[i][2] = nv[i];
            end
        end
    end

    always_comb begin
        job.win                 = win_shift;
        job.first_row           = (row_reg == '0);
        job.mask                = '0;
        job.mask[RES_INNER]     = (row_reg != '0) && (col_reg != '0);
        job.mask[RES_ROW_EDGE]  = (row_reg != '0) && last_col;
        job.mask[RES_LAST_ROW]  = last_row && (col_reg != '0);
        job.mask[RES_LAST_EDGE] = last_row && last_col;
    end

    always_comb begin
        col_next       = col_reg;
        row_next       = row_reg;
        win_next       = win_reg;
        byp_data_next  = {newer, pixel};
        if (accept) begin
            win_next = win_shift;
            if (last_col) begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + FRAME_HEIGHT_W'(1);
            end else begin
                col_next = col_reg + COL_W'(1);
            end
        end
        byp_valid_next = accept && (col_next == col_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg       <= '0;
            row_reg       <= '0;
            byp_valid_reg <= 1'b0;
        end else begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            byp_valid_reg <= byp_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        win_reg      <= win_next;
        byp_data_reg <= byp_data_next;
    end

endmodule

`default_nettype wire

[sv/sobel3_issue.sv]
// Result issue stage: holds one pixel's window and result mask, releases its pending
// results one per cycle, unless stalled, via the output register with the gradients.
// Depends on sobel3_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sobel3_issue
    import sobel3_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic accept,
    input  wire job_t job_in,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    output grad_t     grad_x,
    output grad_t     grad_y,
    output logic      row_end,
    output logic      frame_end
);

    localparam int SUM_W = PIX_W + 2;

    win_t       win_reg, win_next;
    logic       first_reg, first_next;
    res_mask_t  mask_reg, mask_next;
    res_mask_t  pick;
    logic       out_load, fire, single;
    logic       edge_cols, last_rows;
    win_t       rsel, v;
    logic [SUM_W-1:0] sum_l, sum_r, sum_t, sum_b;
    grad_t      gx, gy;

    logic  valid_reg, valid_next;
    grad_t gx_reg, gy_reg;
    logic  row_end_reg, frame_end_reg;

    assign pick      = mask_reg & (~mask_reg + RES_N'(1));
    assign single    = ((mask_reg & (mask_reg - RES_N'(1))) == '0);
    assign out_load  = !valid_reg || out_ready;
    assign fire      = out_load && (mask_reg != '0);
    assign in_ready  = (mask_reg == '0) || (fire && single);

    assign edge_cols = pick[RES_ROW_EDGE] | pick[RES_LAST_EDGE];
    assign last_rows = pick[RES_LAST_ROW] | pick[RES_LAST_EDGE];

    // Last-row results repeat the bottom row below, and on a one-row frame above too.
    always_comb begin
        rsel[0] = last_rows ? (first_reg ? win_reg[2] : win_reg[1]) : win_reg[0];
        rsel[1] = last_rows ? win_reg[2] : win_reg[1];
        rsel[2] = win_reg[2];
        for (int i = 0; i < 3; i++) begin
            v[i][0] = edge_cols ? rsel[i][1] : rsel[i][0];
            v[i][1] = edge_cols ? rsel[i][2] : rsel[i][1];
            v[i][2] = rsel[i][2];
        end
    end

    assign sum_l = SUM_W'(v[0][0]) + {1'b0, v[1][0], 1'b0} + SUM_W'(v[2][0]);
    assign sum_r = SUM_W'(v[0][2]) + {1'b0, v[1][2], 1'b0} + SUM_W'(v[2][2]);
    assign sum_t = SUM_W'(v[0][0]) + {1'b0, v[0][1], 1'b0} + SUM_W'(v[0][2]);
    assign sum_b = SUM_W'(v[2][0]) + {1'b0, v[2][1], 1'b0} + SUM_W'(v[2][2]);
    assign gx    = $signed({1'b0, sum_r}) - $signed({1'b0, sum_l});
    assign gy    = $signed({1'b0, sum_b}) - $signed({1'b0, sum_t});

    always_comb begin
        win_next   = win_reg;
        first_next = first_reg;
        mask_next  = mask_reg;
        if (accept) begin
            win_next   = job_in.win;
            first_next = job_in.first_row;
            mask_next  = job_in.mask;
        end else if (fire) begin
            mask_next  = mask_reg & ~pick;
        end
        valid_next = out_load ? fire : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            mask_reg  <= mask_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        win_reg   <= win_next;
        first_reg <= first_next;
        if (fire) begin
            gx_reg        <= gx;
            gy_reg        <= gy;
            row_end_reg   <= edge_cols;
            frame_end_reg <= pick[RES_LAST_EDGE];
        end
    end

    assign out_valid = valid_reg;
    assign grad_x    = gx_reg;
    assign grad_y    = gy_reg;
    assign row_end   = row_end_reg;
    assign frame_end = frame_end_reg;

endmodule

`default_nettype wire

[sv/sobel3_window_top_note.sv]
// Configuration register block: holds frame width and height written over the
// plain write port.
// Depends on sobel3_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sobel3_cfg
    import sobel3_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_we,
    input  wire logic [CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [CFG_DATA_W-1:0]     cfg_wdata,
    output logic      [FRAME_WIDTH_W-1:0]  frame_width,
    output logic      [FRAME_HEIGHT_W-1:0] frame_height
);

    logic [FRAME_WIDTH_W-1:0]  width_reg, width_next;
    logic [FRAME_HEIGHT_W-1:0] height_reg, height_next;

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  width_next  = cfg_wdata[FRAME_WIDTH_W-1:0];
                REG_FRAME_HEIGHT: height_next = cfg_wdata[FRAME_HEIGHT_W-1:0];
                default: begin
                    width_next  = width_reg;
                    height_next = height_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= FRAME_WIDTH_W'(640);
            height_reg <= FRAME_HEIGHT_W'(480);
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    assign frame_width  = width_reg;
    assign frame_height = height_reg;

endmodule

`default_nettype wire

[sv/sobel_3x3_gradient_stream_core.sv]
// Top level of the 3x3 Sobel gradient stream core.
// Depends on sobel3_pkg, sobel3_cfg, sobel3_window, sobel3_issue and sobel3_ram.
//
// The core takes a raster-order stream of 8-bit grey pixels and gives, for every
// pixel of the frame, the signed horizontal and vertical Sobel gradients with the
// border rows and columns replicated. Each result leaves once its right and lower
// neighbors have arrived: the right border result of a row comes with its left
// neighbor, and the last row is released on the last row's own pixels, so one
// pixel releases zero to four results. m_tlast marks the last result of a row and
// m_tuser the last result of the frame. Frame width and height are to be set over
// the write port between frames; the block does not enforce this. The default is
// 640 by 480. One pixel is taken per clock as long as each pixel releases at most
// one result and the output is not stalled; the single output register moves one
// result per clock while not stalled, so a pixel that releases several results
// holds the input until its last result is loaded. Results pass the mask register
// and then the output register. The line stores need no clearing after reset.
`timescale 1ns / 1ps
`default_nettype none

module sobel_3x3_gradient_stream_core
    import sobel3_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [PIX_W-1:0]       s_tdata,   // [7:0] pixel
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic      [M_TDATA_W-1:0]   m_tdata,   // [10:0] grad_x, [21:11] grad_y, zero pad
    output logic                        m_tlast,   // row_end
    output logic                        m_tuser,   // [0] frame_end
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

    logic [FRAME_WIDTH_W-1:0]  frame_width;
    logic [FRAME_HEIGHT_W-1:0] frame_height;
    logic                      accept;
    job_t                      job;
    grad_t                     grad_x, grad_y;

    assign accept = s_tvalid && s_tready;

    sobel3_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .frame_width (frame_width),
        .frame_height(frame_height)
    );

    sobel3_window #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_window (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .pixel       (s_tdata),
        .frame_width (frame_width),
        .frame_height(frame_height),
        .job         (job)
    );

    sobel3_issue u_issue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .job_in   (job),
        .in_ready (s_tready),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .grad_x   (grad_x),
        .grad_y   (grad_y),
        .row_end  (m_tlast),
        .frame_end(m_tuser)
    );

    assign m_tdata = {(M_TDATA_W - 2 * GRAD_W)'(0), grad_y, grad_x};

endmodule

`default_nettype wire

[test/sobel_3x3_gradient_stream_core_tb.sv]
// Self-checking testbench for sobel_3x3_gradient_stream_core: streams pixel frames
// with random handshake gaps and checks each gradient transfer against a predictor.
// Depends on sobel3_pkg and the core RTL.
`timescale 1ns / 1ps

module sobel_3x3_gradient_stream_core_tb;
    import sobel3_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 7;
    localparam int MAX_WIDTH    = 4096;
    localparam int RANDOM_ITEMS = 360;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_AFTER   = 200;
    localparam int HOLD_CYCLES  = 400;
    localparam int STUCK_LIMIT  = 3000;
    localparam int REPORT_LIMIT = 10;
    localparam pix_t PIX_MAX    = 8'hFF;

    typedef enum int {
        PAT_RANDOM, PAT_ZERO, PAT_FULL, PAT_VEDGE, PAT_VEDGE_INV,
        PAT_HEDGE, PAT_HEDGE_INV, PAT_CHECKER
    } pattern_t;

    typedef logic [8:0][PIX_W-1:0] win9_t;  // [row*3+col], row 0 on top

    typedef struct packed {
        grad_t gx;
        grad_t gy;
        logic  row_end;
        logic  frame_end;
    } grad_pair_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [PIX_W-1:0]       s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tlast;
    logic                   m_tuser;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    sobel_3x3_gradient_stream_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Predictor state, mirroring the core's line stores, window and counters.
    logic [FRAME_WIDTH_W-1:0]  cfg_width  = 13'd640;
    logic [FRAME_HEIGHT_W-1:0] cfg_height = 16'd480;
    bit [PIX_W-1:0]            older_ln [MAX_WIDTH];
    bit [PIX_W-1:0]            newer_ln [MAX_WIDTH];
    win9_t                     pred_win = '0;
    int unsigned               col_cnt  = 0;
    int unsigned               row_cnt  = 0;

    pix_t       pixel_queue [$];
    grad_pair_t pending_grads [$];

    int mismatches = 0;
    int results_checked = 0;

    function automatic grad_pair_t sobel_of(win9_t v, bit row_end, bit frame_end);
        int gx;
        int gy;
        grad_pair_t res;
        gx = -int'(v[0]) + int'(v[2]) - 2 * int'(v[3]) + 2 * int'(v[5])
             - int'(v[6]) + int'(v[8]);
        gy = -int'(v[0]) - 2 * int'(v[1]) - int'(v[2])
             + int'(v[6]) + 2 * int'(v[7]) + int'(v[8]);
        res.gx        = gx[GRAD_W-1:0];
        res.gy        = gy[GRAD_W-1:0];
        res.row_end   = row_end;
        res.frame_end = frame_end;
        return res;
    endfunction

    // The last row has no row below, so its window is rebuilt from the line stores,
    // with the current row replicated downward (and upward on a single-row frame).
    function automatic win9_t edge_window(int unsigned lft, int unsigned mid,
                                          int unsigned rgt, bit first_row);
        win9_t v;
        int unsigned col;
        pix_t cur;
        for (int j = 0; j < 3; j++) begin
            col = (j == 0) ? lft : (j == 1) ? mid : rgt;
            if (col >= MAX_WIDTH) col = MAX_WIDTH - 1;
            cur      = newer_ln[col];
            v[j]     = first_row ? cur : older_ln[col];
            v[3 + j] = cur;
            v[6 + j] = cur;
        end
        return v;
    endfunction

    function automatic void compute_gradients(pix_t p);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        int unsigned ci;
        pix_t o;
        pix_t n;
        pix_t top;
        pix_t nv;
        win9_t v;
        bit last_col;
        bit last_row;
        w = cfg_width;
        if (w < 1) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        h = cfg_height;
        if (h < 1) h = 1;
        c = col_cnt;
        r = row_cnt;
        ci = (c < MAX_WIDTH) ? c : MAX_WIDTH - 1;
        last_col = (c >= w - 1);
        last_row = (r >= h - 1);

        o = older_ln[ci];
        n = newer_ln[ci];
        top = (r <= 1) ? n : o;
        older_ln[ci] = n;
        newer_ln[ci] = p;
        for (int row = 0; row < 3; row++) begin
            nv = (row == 0) ? top : (row == 1) ? n : p;
            if (c == 0) begin
                pred_win[row * 3 + 0] = nv;
                pred_win[row * 3 + 1] = nv;
            end else begin
                pred_win[row * 3 + 0] = pred_win[row * 3 + 1];
                pred_win[row * 3 + 1] = pred_win[row * 3 + 2];
            end
            pred_win[row * 3 + 2] = nv;
        end

        if (r >= 1) begin
            if (c >= 1) pending_grads.push_back(sobel_of(pred_win, 1'b0, 1'b0));
            if (last_col) begin
                // Right border: the rightmost column is replicated.
                for (int row = 0; row < 3; row++) begin
                    v[row * 3 + 0] = pred_win[row * 3 + 1];
                    v[row * 3 + 1] = pred_win[row * 3 + 2];
                    v[row * 3 + 2] = pred_win[row * 3 + 2];
                end
                pending_grads.push_back(sobel_of(v, 1'b1, 1'b0));
            end
        end

        if (last_row) begin
            if (c >= 1) begin
                v = edge_window((c >= 2) ? c - 2 : 0, c - 1, c, r == 0);
                pending_grads.push_back(sobel_of(v, 1'b0, 1'b0));
            end
            if (last_col) begin
                v = edge_window((c >= 1) ? c - 1 : 0, c, c, r == 0);
                pending_grads.push_back(sobel_of(v, 1'b1, 1'b1));
            end
        end

        if (last_col) begin
            col_cnt = 0;
            row_cnt = last_row ? 0 : ((r + 1) & 32'hFFFF);
        end else begin
            col_cnt = (c + 1) & 32'hFFF;
        end
    endfunction

    // Mostly short gaps, a few long ones, and now and then a calm stretch with none.
    function automatic int pick_gap(inout int calm);
        int roll;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 2) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic pix_t pixel_at(pattern_t pat, int x, int y, int w, int h);
        case (pat)
            PAT_ZERO:      return '0;
            PAT_FULL:      return PIX_MAX;
            PAT_VEDGE:     return (x < w / 2) ? '0 : PIX_MAX;
            PAT_VEDGE_INV: return (x < w / 2) ? PIX_MAX : '0;
            PAT_HEDGE:     return (y < h / 2) ? '0 : PIX_MAX;
            PAT_HEDGE_INV: return (y < h / 2) ? PIX_MAX : '0;
            PAT_CHECKER:   return ((x + y) % 2 != 0) ? PIX_MAX : '0;
            default:       return pix_t'($urandom_range(0, 255));
        endcase
    endfunction

    // Queues a raster of cols by rows pixels; returns the number queued.
    function automatic int queue_frame(int w, int h, pattern_t pat);
        int cols;
        int rows;
        cols = (w < 1) ? 1 : (w > MAX_WIDTH) ? MAX_WIDTH : w;
        rows = (h < 1) ? 1 : h;
        for (int y = 0; y < rows; y++)
            for (int x = 0; x < cols; x++)
                pixel_queue.push_back(pixel_at(pat, x, y, cols, rows));
        return cols * rows;
    endfunction

    task automatic wait_idle();
        do @(posedge aclk);
        while (pixel_queue.size() != 0 || s_tvalid || pending_grads.size() != 0);
        // A pixel that releases no result may still be in flight.
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, int unsigned val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val[CFG_DATA_W-1:0];
        case (idx)
            REG_FRAME_WIDTH:  cfg_width  = val[FRAME_WIDTH_W-1:0];
            REG_FRAME_HEIGHT: cfg_height = val[FRAME_HEIGHT_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_frame(int unsigned w, int unsigned h);
        wait_idle();
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
    endtask

    // Pixel sender.
    int tx_gap = 0;
    int tx_calm = 0;
    bit tx_offer;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            tx_offer = s_tvalid;
            if (s_tvalid && s_tready) begin
                compute_gradients(s_tdata);
                tx_offer = 1'b0;
            end
            if (!tx_offer) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (pixel_queue.size() != 0) begin
                    s_tdata  <= pixel_queue.pop_front();
                    tx_offer = 1'b1;
                    tx_gap   = pick_gap(tx_calm);
                end
            end
            s_tvalid <= tx_offer;
        end
    end

    // Result receiver; holds off once for a long stretch so the core backs up.
    int rx_gap = 0;
    int rx_calm = 0;
    int rx_hold = 0;
    int rx_count = 0;
    bit hold_done = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) rx_count++;
            if (!hold_done && rx_count >= HOLD_AFTER) begin
                hold_done = 1'b1;
                rx_hold   = HOLD_CYCLES;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                m_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                rx_gap = pick_gap(rx_calm);
            end
        end
    end

    // Result checker.
    grad_pair_t got;
    grad_pair_t want;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got.gx        = m_tdata[GRAD_W-1:0];
            got.gy        = m_tdata[2*GRAD_W-1:GRAD_W];
            got.row_end   = m_tlast;
            got.frame_end = m_tuser;
            if (pending_grads.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected result %0d: gx %0d gy %0d row_end %0b frame_end %0b",
                             $realtime, results_checked, $signed(got.gx), $signed(got.gy),
                             got.row_end, got.frame_end);
            end else begin
                want = pending_grads.pop_front();
                if (got.gx !== want.gx || got.gy !== want.gy ||
                    got.row_end !== want.row_end || got.frame_end !== want.frame_end) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $write("%0t: result %0d: expected gx %0d gy %0d row_end %0b ",
                               $realtime, results_checked,
                               $signed(want.gx), $signed(want.gy), want.row_end);
                        $display("frame_end %0b, got gx %0d gy %0d row_end %0b frame_end %0b",
                                 want.frame_end, $signed(got.gx), $signed(got.gy),
                                 got.row_end, got.frame_end);
                    end
                end
            end
            results_checked++;
        end
    end

    // Watchdog: ends the run when neither side has moved a transfer for too long.
    int stuck_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    int sent;
    int w_pick;
    int h_pick;
    int roll;
    pattern_t pat;

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: full-scale gradients of both signs, all-ones pixels, and the
        // degenerate sizes (width 0 or 1, height 0 or 1).
        set_frame(2, 2);
        sent = queue_frame(2, 2, PAT_VEDGE);
        sent = queue_frame(2, 2, PAT_VEDGE_INV);
        sent = queue_frame(2, 2, PAT_HEDGE);
        sent = queue_frame(2, 2, PAT_HEDGE_INV);
        set_frame(1, 3);
        sent = queue_frame(1, 3, PAT_RANDOM);
        set_frame(0, 2);
        sent = queue_frame(0, 2, PAT_RANDOM);
        set_frame(3, 0);
        sent = queue_frame(3, 0, PAT_RANDOM);
        set_frame(2, 1);
        sent = queue_frame(2, 1, PAT_FULL);

        // Random frames of mostly small sizes; some chain back to back without a
        // configuration change, the rest wait for the core to drain first.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 2) != 0) begin
                roll = $urandom_range(0, 99);
                w_pick = (roll < 80) ? $urandom_range(2, 10) :
                         (roll < 90) ? $urandom_range(0, 1) : $urandom_range(11, 24);
                roll = $urandom_range(0, 99);
                h_pick = (roll < 75) ? $urandom_range(2, 6) :
                         (roll < 90) ? $urandom_range(0, 1) : $urandom_range(7, 10);
                set_frame(w_pick, h_pick);
            end
            pat = ($urandom_range(0, 99) < 80) ? PAT_RANDOM
                                               : pattern_t'($urandom_range(0, PAT_CHECKER));
            sent += queue_frame(cfg_width, cfg_height, pat);
        end

        // Height lowered mid-frame: the row in progress becomes the last one.
        set_frame(3, 65535);
        sent = queue_frame(15, 1, PAT_RANDOM);
        wait_idle();
        write_reg(REG_FRAME_HEIGHT, 2);
        sent = queue_frame(3, 1, PAT_RANDOM);

        // Width lowered mid-row: the current pixel already lies past the new row end.
        set_frame(10, 4);
        sent = queue_frame(15, 1, PAT_RANDOM);
        wait_idle();
        write_reg(REG_FRAME_WIDTH, 3);
        sent = queue_frame(7, 1, PAT_RANDOM);

        set_frame(5, 4);
        sent = queue_frame(5, 4, PAT_CHECKER);

        wait_idle();
        if (mismatches == 0 && pending_grads.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[files.f]
sv/sobel3_pkg.sv
sv/sobel3_ram.sv
sv/sobel3_window.sv
sv/sobel3_issue.sv
sv/sobel3_window_top_note.sv
sv/sobel_3x3_gradient_stream_core.sv
test/sobel_3x3_gradient_stream_core_tb.sv
